// ===== hw/rtl/i2sdc_pkg.sv =====
// Shared widths, register indexes and reset values for the I2S DC blocker.
package i2sdc_pkg;

    localparam int WordW    = 32;
    localparam int SampleW  = 24;
    localparam int DiffW    = SampleW + 1;
    localparam int FracW    = 16;
    localparam int YW       = 50;
    localparam int SumW     = YW + 2;
    localparam int CoefW    = 16;
    localparam int ShiftW   = 4;
    localparam int OutW     = 16;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;
    localparam int YHalfW   = YW / 2;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MIC_SLOT   = 2'd0,
        CFG_POLE_COEF  = 2'd1,
        CFG_GAIN_SHIFT = 2'd2
    } t_cfg_index;

    localparam logic              MicSlotReset = 1'b0;
    localparam logic [CoefW-1:0]  PoleReset    = 16'd65202;
    localparam logic [ShiftW-1:0] ShiftReset   = 4'd5;

    typedef logic signed [YW-1:0]      t_acc;
    typedef logic signed [SampleW-1:0] t_sample24;

endpackage

// ===== hw/rtl/i2sdc_if.sv =====
// Valid/ready channel interfaces for the frame input and the sample output.
interface i2sdc_frame_if
    import i2sdc_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic signed [WordW-1:0]  slot0_word;
    logic signed [WordW-1:0]  slot1_word;
    logic                     end_of_block;

    modport source (output valid, output slot0_word, output slot1_word,
                    output end_of_block, input ready);
    modport sink   (input valid, input slot0_word, input slot1_word,
                    input end_of_block, output ready);
endinterface

interface i2sdc_sample_if
    import i2sdc_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    logic signed [OutW-1:0]  sample;
    logic                    block_last;

    modport source (output valid, output sample, output block_last, input ready);
    modport sink   (input valid, input sample, input block_last, output ready);
endinterface

// ===== hw/rtl/i2s_dc_block_gain_saturate.sv =====
// Top level: slot select, fixed-point DC blocking filter, gain, rounding, saturation.
// Path: a transferred frame is registered as the selected sample, then as the filter output,
// then in the result register, from which it is offered as a sample.
// Throughput: one frame per cycle unless the output stalls; the filter recursion is combinational.
// Reset (synchronous, active low) empties the pipeline, clears the filter state
// and restores mic_slot 0, pole_coefficient 65202 and gain_shift 5.
module i2s_dc_block_gain_saturate
    import i2sdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CfgIdxW-1:0]   i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data,
    i2sdc_frame_if.sink          i_frame,
    i2sdc_sample_if.source       o_sample
);

    // Configuration registers.
    logic               r_mic_slot;
    logic [CoefW-1:0]   r_pole;
    logic [ShiftW-1:0]  r_gain;

    // Stage 1: selected 24-bit sample.
    logic       r_v1;
    t_sample24  r_x;
    logic       r_eob1;
    // Stage 2: filter output.
    logic       r_v2;
    t_acc       r_y;
    logic       r_eob2;
    // Stage 3: result register.
    logic                   r_v3;
    logic signed [OutW-1:0] r_sample;
    logic                   r_eob3;

    // Filter state, advanced each time a sample passes through the filter.
    t_sample24  r_x_prev;
    t_acc       r_y_prev;

    // Stall control: a stage moves when the stage after it is empty or moving.
    logic adv1, adv2, adv3;
    assign adv3 = !r_v3 || o_sample.ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign i_frame.ready = adv1;

    logic in_xfer, flt_xfer;
    assign in_xfer  = i_frame.valid && adv1;
    assign flt_xfer = r_v1 && adv2;

    t_sample24 n_x;
    assign n_x = r_mic_slot ? i_frame.slot1_word[WordW-1:WordW-SampleW]
                            : i_frame.slot0_word[WordW-1:WordW-SampleW];

    // The feedback product R * y_prev is built from two narrow partial products,
    // one for the signed upper half of y_prev and one for its unsigned lower half.
    // Flooring by 2^16 is then just dropping the low bits of the exact product.
    localparam int PHiW  = CoefW + 1 + (YW - YHalfW);
    localparam int PLoW  = CoefW + YHalfW;
    localparam int FullW = SumW + FracW;
    localparam logic signed [SumW-1:0] YMax = SumW'((64'd1 << (YW-1)) - 64'd1);
    localparam logic signed [SumW-1:0] YMin = -SumW'(64'd1 << (YW-1));

    logic signed [YW-YHalfW-1:0] y_hi;
    logic [YHalfW-1:0]           y_lo;
    logic signed [PHiW-1:0]      p_hi;
    logic [PLoW-1:0]             p_lo;
    logic signed [FullW-1:0]     p_full;
    logic signed [SumW-1:0]      feedback;
    logic signed [DiffW-1:0]     diff;
    logic signed [SumW-1:0]      y_sum;
    t_acc                        n_y;

    always_comb begin
        y_hi     = r_y_prev[YW-1:YHalfW];
        y_lo     = r_y_prev[YHalfW-1:0];
        p_hi     = $signed({1'b0, r_pole}) * y_hi;
        p_lo     = r_pole * y_lo;
        p_full   = (FullW'(p_hi) <<< YHalfW) + $signed(FullW'(p_lo));
        feedback = p_full[FullW-1:FracW];
        diff     = DiffW'(r_x) - DiffW'(r_x_prev);
        y_sum    = (SumW'(diff) <<< FracW) + feedback;
        // The stored output saturates at the signed 50-bit range.
        if (y_sum > YMax) begin
            n_y = YMax[YW-1:0];
        end else if (y_sum < YMin) begin
            n_y = YMin[YW-1:0];
        end else begin
            n_y = y_sum[YW-1:0];
        end
    end

    logic signed [OutW-1:0] n_sample;

    i2sdc_round_sat u_round_sat (
        .i_y      (r_y),
        .i_shift  (r_gain),
        .o_sample (n_sample)
    );

    // Configuration writes; an index past the last register is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mic_slot <= MicSlotReset;
            r_pole     <= PoleReset;
            r_gain     <= ShiftReset;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MIC_SLOT:   r_mic_slot <= i_cfg_data[0];
                CFG_POLE_COEF:  r_pole     <= i_cfg_data[CoefW-1:0];
                CFG_GAIN_SHIFT: r_gain     <= i_cfg_data[ShiftW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Valid bits and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_x_prev <= '0;
            r_y_prev <= '0;
        end else begin
            if (adv1) begin
                r_v1 <= i_frame.valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (flt_xfer) begin
                r_x_prev <= r_x;
                r_y_prev <= n_y;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x    <= n_x;
            r_eob1 <= i_frame.end_of_block;
        end
        if (flt_xfer) begin
            r_y    <= n_y;
            r_eob2 <= r_eob1;
        end
        if (adv3 && r_v2) begin
            r_sample <= n_sample;
            r_eob3   <= r_eob2;
        end
    end

    assign o_sample.valid      = r_v3;
    assign o_sample.sample     = r_sample;
    assign o_sample.block_last = r_eob3;

endmodule

// ===== hw/rtl/i2sdc_round_sat.sv =====
// Output scaling: divide by 2^(16+shift), round half to even, saturate to int16.
module i2sdc_round_sat
    import i2sdc_pkg::*;
(
    input  t_acc                    i_y,
    input  logic [ShiftW-1:0]       i_shift,
    output logic signed [OutW-1:0]  o_sample
);

    localparam logic signed [YW:0] QMax = (YW+1)'(32767);
    localparam logic signed [YW:0] QMin = -(YW+1)'(32768);

    logic [ShiftW:0]     s_amt;
    t_acc                s_q;
    logic [YW-1:0]       s_low_mask;
    logic [YW-1:0]       s_rem;
    logic [YW-1:0]       s_half;
    logic                s_up;
    logic signed [YW:0]  s_qr;

    always_comb begin
        s_amt      = (ShiftW+1)'(FracW) + {1'b0, i_shift};
        s_q        = i_y >>> s_amt;
        s_low_mask = ~({YW{1'b1}} << s_amt);
        s_rem      = i_y & s_low_mask;
        s_half     = YW'(1) << (s_amt - (ShiftW+1)'(1));
        // Round up past the half point, or at exactly half when the quotient is odd.
        s_up       = (s_rem > s_half) || ((s_rem == s_half) && s_q[0]);
        s_qr       = {s_q[YW-1], s_q} + (YW+1)'(s_up);
        if (s_qr > QMax) begin
            o_sample = QMax[OutW-1:0];
        end else if (s_qr < QMin) begin
            o_sample = QMin[OutW-1:0];
        end else begin
            o_sample = s_qr[OutW-1:0];
        end
    end

endmodule
